// ===== src/shortest_path_dijkstra_macros.svh =====
// Assertion macros for the shortest path block.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef SHORTEST_PATH_DIJKSTRA_MACROS_SVH
`define SHORTEST_PATH_DIJKSTRA_MACROS_SVH

`ifndef SYNTHESIS
`define SPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spd assertion failed");
`define SPD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spd assertion failed");
`else
`define SPD_ASSERT_IMP(lbl, ante, cons)
`define SPD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/spd_pkg.sv =====
// Shared types and constants for the shortest path block.
// No dependencies.
package spd_pkg;

    localparam int NODE_AW    = 10;
    localparam int NODE_CNT_W = NODE_AW + 1;
    localparam int EDGE_AW    = 12;
    localparam int EDGE_CNT_W = EDGE_AW + 1;
    localparam int DIST_W     = 24;
    localparam int WEIGHT_W   = 14;

    localparam logic [NODE_CNT_W-1:0] MAX_NODES = NODE_CNT_W'(1 << NODE_AW);
    localparam logic [EDGE_CNT_W-1:0] MAX_EDGES = EDGE_CNT_W'(1 << EDGE_AW);
    localparam logic [DIST_W-1:0]     DIST_MAX  = '1;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]            func;
        logic [NODE_AW-1:0]    node_a;
        logic [NODE_AW-1:0]    node_b;
        logic [WEIGHT_W-1:0]   weight;
        logic [NODE_CNT_W-1:0] node_count;
    } cmd_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              reachable;
    } res_t;

    typedef struct packed {
        logic [NODE_AW-1:0]  a;
        logic [NODE_AW-1:0]  b;
        logic [WEIGHT_W-1:0] w;
    } edge_t;

    typedef struct packed {
        logic              fin;
        logic              inf;
        logic [DIST_W-1:0] cost;
    } node_t;

    localparam int EDGE_W = $bits(edge_t);
    localparam int NODE_W = $bits(node_t);

    typedef struct packed {
        logic                we;
        logic [NODE_AW-1:0]  waddr;
        node_t               wdata;
        logic [NODE_AW-1:0]  raddr;
    } node_port_t;

    typedef struct packed {
        logic                we;
        logic [EDGE_AW-1:0]  waddr;
        edge_t               wdata;
        logic [EDGE_AW-1:0]  raddr;
    } edge_port_t;

    typedef struct packed {
        logic [DIST_W-1:0]   base;
        logic [WEIGHT_W-1:0] addend;
        logic [DIST_W-1:0]   cur;
        logic                cur_inf;
    } unit_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] sum;
        logic              less;
    } unit_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_EREAD,
        S_EDEC,
        S_ERELAX,
        S_DST
    } state_t;

endpackage

// ===== src/shortest_path_dijkstra.sv =====
// Top level of the single-source shortest path block.
// Depends on spd_pkg, spd_ram, spd_unit, spd_seq and the assertion macro header.
//
// Usage:
//   An item on cmd is taken at a clock edge with start high and busy low.
//   func add edge stores one undirected edge per cycle; busy stays low, so
//   edges load back to back. An edge that finds the store full is dropped.
//   func clear empties the edge store. Code 3 does nothing.
//   func run query raises busy and searches from node_a; when done, the
//   distance to node_b appears on res with res_valid high for one cycle.
//   A query with an endpoint outside node_count answers unreachable in the
//   cycle after it is taken, without raising busy.
//   A query, for N nodes (node_count capped at 1024), E stored edges and
//   K nodes reached: N init writes, then K + 1 scan passes over the N nodes,
//   K passes over the E stored edges if E > 0, then a read of the target.
//   The shared add/compare unit and the single node RAM port bound its speed.
//   The receiver cannot stall: res is valid for exactly one cycle.
//   Reset empties the edge store and returns to idle; RAM contents are not
//   cleared, since every query rewrites its node entries first.
`include "shortest_path_dijkstra_macros.svh"

module shortest_path_dijkstra (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  spd_pkg::cmd_t cmd,
    output logic          busy,
    output logic          res_valid,
    output spd_pkg::res_t res
);
    import spd_pkg::*;

    node_port_t node_port;
    node_t      node_rdata;
    edge_port_t edge_port;
    edge_t      edge_rdata;
    unit_in_t   ui;
    unit_out_t  uo;
    logic       query_run;
    logic       load_take;

    spd_ram #(
        .DATA_W (NODE_W),
        .ADDR_W (NODE_AW)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_port.we),
        .waddr (node_port.waddr),
        .wdata (node_port.wdata),
        .raddr (node_port.raddr),
        .rdata (node_rdata)
    );

    spd_ram #(
        .DATA_W (EDGE_W),
        .ADDR_W (EDGE_AW)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_port.we),
        .waddr (edge_port.waddr),
        .wdata (edge_port.wdata),
        .raddr (edge_port.raddr),
        .rdata (edge_rdata)
    );

    spd_unit u_unit (
        .ui (ui),
        .uo (uo)
    );

    spd_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .res_valid  (res_valid),
        .res        (res),
        .node_port  (node_port),
        .node_rdata (node_rdata),
        .edge_port  (edge_port),
        .edge_rdata (edge_rdata),
        .ui         (ui),
        .uo         (uo)
    );

    assign query_run = start && !busy && (cmd.func == FUNC_QUERY) &&
                       ({1'b0, cmd.node_a} < cmd.node_count) &&
                       ({1'b0, cmd.node_b} < cmd.node_count);
    assign load_take = start && !busy && (cmd.func != FUNC_QUERY);

    `SPD_ASSERT_NXT(a_query_runs, query_run, busy)
    `SPD_ASSERT_NXT(a_no_result_for_load, load_take, !res_valid)
    `SPD_ASSERT_IMP(a_unreach_zero, res_valid && !res.reachable, res.distance == '0)
    `SPD_ASSERT_IMP(a_query_ends_with_result, $fell(busy), res_valid)

endmodule

// ===== src/spd_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module spd_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/spd_unit.sv =====
// Shared saturating add and compare unit for node scan and edge relaxation.
// Depends on spd_pkg.
module spd_unit (
    input  spd_pkg::unit_in_t  ui,
    output spd_pkg::unit_out_t uo
);
    import spd_pkg::*;

    logic [DIST_W:0] sum_wide;

    always_comb
    begin
        sum_wide = {1'b0, ui.base} + {{(DIST_W + 1 - WEIGHT_W){1'b0}}, ui.addend};
        uo.sum   = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
        uo.less  = ui.cur_inf || (uo.sum < ui.cur);
    end

endmodule

// ===== src/spd_seq.sv =====
// Sequencer: edge loading, distance init, nearest-node scan, edge relaxation.
// Depends on spd_pkg; drives both RAMs and the shared unit.
module spd_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  spd_pkg::cmd_t      cmd,
    output logic               busy,
    output logic               res_valid,
    output spd_pkg::res_t      res,
    output spd_pkg::node_port_t node_port,
    input  spd_pkg::node_t     node_rdata,
    output spd_pkg::edge_port_t edge_port,
    input  spd_pkg::edge_t     edge_rdata,
    output spd_pkg::unit_in_t  ui,
    input  spd_pkg::unit_out_t uo
);
    import spd_pkg::*;

    state_t                state_reg, state_next;
    logic [NODE_CNT_W-1:0] n_reg, n_next;
    logic [NODE_AW-1:0]    src_reg, src_next;
    logic [NODE_AW-1:0]    dst_reg, dst_next;
    logic [NODE_CNT_W-1:0] idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic [NODE_AW-1:0]    pidx_reg, pidx_next;
    logic                  found_reg, found_next;
    logic [DIST_W-1:0]     best_reg, best_next;
    logic [NODE_AW-1:0]    u_reg, u_next;
    logic [EDGE_CNT_W-1:0] eidx_reg, eidx_next;
    logic [EDGE_CNT_W-1:0] total_reg, total_next;
    logic [NODE_AW-1:0]    tgt_reg, tgt_next;
    logic [WEIGHT_W-1:0]   w_reg, w_next;
    logic                  res_valid_reg, res_valid_next;
    res_t                  res_reg, res_next;

    logic issue;
    logic edge_ok;
    logic hit_a;
    logic hit_b;
    logic last_edge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        src_reg  <= src_next;
        dst_reg  <= dst_next;
        idx_reg  <= idx_next;
        pidx_reg <= pidx_next;
        best_reg <= best_next;
        u_reg    <= u_next;
        eidx_reg <= eidx_next;
        tgt_reg  <= tgt_next;
        w_reg    <= w_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        u_next         = u_reg;
        eidx_next      = eidx_reg;
        total_next     = total_reg;
        tgt_next       = tgt_reg;
        w_next         = w_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        node_port       = '0;
        node_port.raddr = idx_reg[NODE_AW-1:0];
        edge_port       = '0;
        edge_port.raddr = eidx_reg[EDGE_AW-1:0];
        edge_port.waddr = total_reg[EDGE_AW-1:0];
        edge_port.wdata = '{a: cmd.node_a, b: cmd.node_b, w: cmd.weight};

        ui.base    = node_rdata.cost;
        ui.addend  = '0;
        ui.cur     = best_reg;
        ui.cur_inf = !found_reg;

        issue     = idx_reg < n_reg;
        edge_ok   = ({1'b0, edge_rdata.a} < n_reg) && ({1'b0, edge_rdata.b} < n_reg);
        hit_a     = edge_rdata.a == u_reg;
        hit_b     = edge_rdata.b == u_reg;
        last_edge = (eidx_reg + EDGE_CNT_W'(1)) == total_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.func)
                        FUNC_ADD:
                        begin
                            if (total_reg < MAX_EDGES)
                            begin
                                edge_port.we = 1'b1;
                                total_next   = total_reg + EDGE_CNT_W'(1);
                            end
                        end
                        FUNC_QUERY:
                        begin
                            if (({1'b0, cmd.node_a} < cmd.node_count) &&
                                ({1'b0, cmd.node_b} < cmd.node_count))
                            begin
                                n_next     = (cmd.node_count > MAX_NODES) ? MAX_NODES
                                                                          : cmd.node_count;
                                src_next   = cmd.node_a;
                                dst_next   = cmd.node_b;
                                idx_next   = '0;
                                state_next = S_INIT;
                            end
                            else
                            begin
                                res_valid_next = 1'b1;
                                res_next       = '0;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            total_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_INIT:
            begin
                node_port.we    = 1'b1;
                node_port.waddr = idx_reg[NODE_AW-1:0];
                node_port.wdata = '{fin: 1'b0, inf: (idx_reg[NODE_AW-1:0] != src_reg),
                                    cost: '0};
                if (idx_reg == n_reg - NODE_CNT_W'(1))
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    idx_next = idx_reg + NODE_CNT_W'(1);
                end
            end

            S_SCAN:
            begin
                if (issue)
                begin
                    idx_next  = idx_reg + NODE_CNT_W'(1);
                    pend_next = 1'b1;
                    pidx_next = idx_reg[NODE_AW-1:0];
                end
                if (pend_reg && !node_rdata.fin && !node_rdata.inf && uo.less)
                begin
                    best_next  = node_rdata.cost;
                    u_next     = pidx_reg;
                    found_next = 1'b1;
                end
                if (!issue && !pend_reg)
                begin
                    if (found_reg)
                    begin
                        node_port.we    = 1'b1;
                        node_port.waddr = u_reg;
                        node_port.wdata = '{fin: 1'b1, inf: 1'b0, cost: best_reg};
                        eidx_next       = '0;
                        if (total_reg == '0)
                        begin
                            idx_next   = '0;
                            found_next = 1'b0;
                        end
                        else
                        begin
                            state_next = S_EREAD;
                        end
                    end
                    else
                    begin
                        node_port.raddr = dst_reg;
                        state_next      = S_DST;
                    end
                end
            end

            S_EREAD:
            begin
                state_next = S_EDEC;
            end

            S_EDEC:
            begin
                if (edge_ok && (hit_a || hit_b))
                begin
                    tgt_next        = hit_a ? edge_rdata.b : edge_rdata.a;
                    node_port.raddr = hit_a ? edge_rdata.b : edge_rdata.a;
                    w_next          = edge_rdata.w;
                    state_next      = S_ERELAX;
                end
                else if (last_edge)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    eidx_next  = eidx_reg + EDGE_CNT_W'(1);
                    state_next = S_EREAD;
                end
            end

            S_ERELAX:
            begin
                ui.base    = best_reg;
                ui.addend  = w_reg;
                ui.cur     = node_rdata.cost;
                ui.cur_inf = node_rdata.inf;
                if (uo.less)
                begin
                    node_port.we    = 1'b1;
                    node_port.waddr = tgt_reg;
                    node_port.wdata = '{fin: node_rdata.fin, inf: 1'b0, cost: uo.sum};
                end
                if (last_edge)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    eidx_next  = eidx_reg + EDGE_CNT_W'(1);
                    state_next = S_EREAD;
                end
            end

            S_DST:
            begin
                res_valid_next = 1'b1;
                if (node_rdata.inf)
                begin
                    res_next = '0;
                end
                else
                begin
                    res_next = '{distance: node_rdata.cost, reachable: 1'b1};
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy      = state_reg != S_IDLE;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== sim/spd_route_checker.sv =====
`timescale 1ns / 100ps
// Route checker for shortest_path_dijkstra: watches the command and result ports,
// predicts each query answer from its own edge store and compares field by field.
// Depends on spd_pkg.
module spd_route_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  spd_pkg::cmd_t cmd,
    input  logic          busy,
    input  logic          res_valid,
    input  spd_pkg::res_t res,
    output int            mismatches,
    output int            outstanding
);
    import spd_pkg::*;

    localparam int          NODE_SLOTS = 1 << NODE_AW;
    localparam int          EDGE_SLOTS = 1 << EDGE_AW;
    localparam int unsigned UNSEEN     = 32'hFFFF_FFFF;

    edge_t       edge_mem [EDGE_SLOTS];
    int          edge_total;
    int unsigned node_dist [NODE_SLOTS];
    bit          node_done [NODE_SLOTS];
    res_t        expected_routes [$];
    res_t        route_want;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void relax_node(input int to, input int unsigned base,
                                       input int unsigned w);
        int unsigned sum;
        sum = base + w;
        if (sum > DIST_MAX)
            sum = DIST_MAX;
        if (sum < node_dist[to])
            node_dist[to] = sum;
    endfunction

    function automatic res_t route_distance(input cmd_t c);
        int unsigned n;
        int unsigned best;
        int          u;
        bit          found;
        res_t        r;
        r = '0;
        n = c.node_count;
        if (n > NODE_SLOTS)
            n = NODE_SLOTS;
        if (c.node_a >= n || c.node_b >= n)
            return r;
        for (int i = 0; i < n; i++)
        begin
            node_dist[i] = UNSEEN;
            node_done[i] = 1'b0;
        end
        node_dist[c.node_a] = 0;
        found = 1'b1;
        while (found)
        begin
            best  = UNSEEN;
            u     = 0;
            found = 1'b0;
            // pick the nearest open node, lowest index on ties
            for (int i = 0; i < n; i++)
            begin
                if (!node_done[i] && node_dist[i] < best)
                begin
                    best  = node_dist[i];
                    u     = i;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                node_done[u] = 1'b1;
                for (int k = 0; k < edge_total; k++)
                begin
                    if (edge_mem[k].a < n && edge_mem[k].b < n)
                    begin
                        if (edge_mem[k].a == u)
                            relax_node(edge_mem[k].b, best, edge_mem[k].w);
                        if (edge_mem[k].b == u)
                            relax_node(edge_mem[k].a, best, edge_mem[k].w);
                    end
                end
            end
        end
        if (node_dist[c.node_b] != UNSEEN)
        begin
            r.distance  = DIST_W'(node_dist[c.node_b]);
            r.reachable = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_total = 0;
            expected_routes.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (res_valid)
            begin
                if (expected_routes.size() == 0)
                    report_mismatch($sformatf("unexpected result distance %0d reachable %0b",
                                              res.distance, res.reachable));
                else
                begin
                    route_want = expected_routes.pop_front();
                    if (res.distance !== route_want.distance)
                        report_mismatch($sformatf("distance %0d, want %0d",
                                                  res.distance, route_want.distance));
                    if (res.reachable !== route_want.reachable)
                        report_mismatch($sformatf("reachable %0b, want %0b",
                                                  res.reachable, route_want.reachable));
                end
            end
            if (start && !busy)
            begin
                case (cmd.func)
                    FUNC_ADD:
                    begin
                        // drop the edge when the store is full
                        if (edge_total < EDGE_SLOTS)
                        begin
                            edge_mem[edge_total] = '{cmd.node_a, cmd.node_b, cmd.weight};
                            edge_total++;
                        end
                    end
                    FUNC_QUERY:
                        expected_routes.insert(expected_routes.size(), route_distance(cmd));
                    FUNC_CLEAR: edge_total = 0;
                    default: ;
                endcase
            end
            outstanding = expected_routes.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Top of the shortest_path_dijkstra regression: clock, reset, command stimulus
// and verdict. Depends on spd_pkg, the block and spd_route_checker.
module testbench;
    import spd_pkg::*;

    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS   = 420;
    localparam int         WATCHDOG_LIMIT = 1_000_000;
    localparam int         CMD_W          = $bits(cmd_t);

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic res_valid;
    cmd_t cmd;
    res_t res;
    int   mismatches;
    int   outstanding;
    int   stalled_cycles;
    int   random_sent;
    bit   calm;

    shortest_path_dijkstra dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res)
    );

    spd_route_checker route_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .busy        (busy),
        .res_valid   (res_valid),
        .res         (res),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stalled_cycles <= 0;
        else if ((start && !busy) || res_valid)
            stalled_cycles <= 0;
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("shortest_path_dijkstra regression: fail");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    function automatic int pick_weight();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 16383;
            2, 3, 4: return $urandom_range(0, 16383);
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic cmd_t edge_item(input int a, input int b, input int w);
        cmd_t c;
        c.func       = FUNC_ADD;
        c.node_a     = NODE_AW'(a);
        c.node_b     = NODE_AW'(b);
        c.weight     = WEIGHT_W'(w);
        c.node_count = NODE_CNT_W'($urandom_range(0, 2047));
        return c;
    endfunction

    function automatic cmd_t query_item(input int n, input int src, input int dst);
        cmd_t c;
        c.func       = FUNC_QUERY;
        c.node_a     = NODE_AW'(src);
        c.node_b     = NODE_AW'(dst);
        c.weight     = WEIGHT_W'($urandom_range(0, 16383));
        c.node_count = NODE_CNT_W'(n);
        return c;
    endfunction

    function automatic cmd_t clear_item();
        cmd_t c;
        c = cmd_t'(CMD_W'({$urandom, $urandom}));
        c.func = FUNC_CLEAR;
        return c;
    endfunction

    function automatic cmd_t unused_item();
        cmd_t c;
        c = cmd_t'(CMD_W'({$urandom, $urandom}));
        c.func = FUNC_UNUSED;
        return c;
    endfunction

    // hold start until taken, then idle now and then
    task automatic send_item(input cmd_t c);
        cmd   <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < 16)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic run_session();
        int  n;
        int  span;
        int  qn;
        int  roll;
        bit  big;
        big  = ($urandom_range(0, 9) == 0);
        n    = big ? $urandom_range(200, 2047) : $urandom_range(1, 24);
        span = (n > 1024) ? 1024 : n;
        calm = (random_sent >= 120 && random_sent < 260);
        send_item(clear_item());
        random_sent++;
        repeat ($urandom_range(6, 36))
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                send_item(unused_item());
            else if (roll < 30)
            begin
                qn = ($urandom_range(0, 5) == 0) ? $urandom_range(0, span + 2) : n;
                if ($urandom_range(0, 99) < 85)
                    send_item(query_item(qn, $urandom_range(0, span - 1),
                                         $urandom_range(0, span - 1)));
                else
                    send_item(query_item(qn, $urandom_range(0, 1023),
                                         $urandom_range(0, 1023)));
                random_sent++;
            end
            else
            begin
                if ($urandom_range(0, 99) < 85)
                    send_item(edge_item($urandom_range(0, span - 1),
                                        $urandom_range(0, span - 1), pick_weight()));
                else
                    send_item(edge_item($urandom_range(0, 1023), $urandom_range(0, 1023),
                                        $urandom_range(0, 16383)));
                random_sent++;
            end
        end
        send_item(query_item(n, $urandom_range(0, span - 1), $urandom_range(0, span - 1)));
        random_sent++;
        if ($urandom_range(0, 7) == 0)
            drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        calm        = 1'b0;
        random_sent = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(query_item(1, 0, 0));
        send_item(query_item(0, 0, 0));
        send_item(edge_item(0, 1, 16383));
        send_item(edge_item(1, 2, 0));
        send_item(edge_item(2, 2, 5));
        send_item(edge_item(1023, 3, 7));
        send_item(edge_item(3, 0, 1));
        send_item(edge_item(3, 2, 16383));
        send_item(query_item(3, 0, 2));
        send_item(query_item(4, 0, 2));
        send_item(query_item(2047, 1023, 2));
        send_item(query_item(1024, 0, 1023));
        send_item(query_item(3, 1023, 0));
        send_item(query_item(3, 0, 1023));
        send_item(cmd_t'('1));
        send_item(clear_item());
        send_item(query_item(4, 0, 1));
        send_item(query_item(1, 0, 0));
        drain();

        while (random_sent < RANDOM_ITEMS)
            run_session();
        calm = 1'b0;

        drain();
        repeat (16) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("shortest_path_dijkstra regression: pass");
        else
            $display("shortest_path_dijkstra regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/spd_pkg.sv
src/spd_ram.sv
src/spd_unit.sv
src/spd_seq.sv
src/shortest_path_dijkstra.sv
sim/spd_route_checker.sv
sim/testbench.sv
